// ===== rtl/core/wcsp_pkg.sv =====
// Package: shared types and constants for the WAV chunk stream parser.
package wcsp_pkg;

  localparam int unsigned POS_BITS = 32;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam int unsigned RIFF_HDR_BYTES = 12;
  localparam int unsigned CHUNK_HDR_BYTES = 8;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] CH_MAX = 16'd2;
  localparam logic [15:0] BITS_8 = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;

  typedef enum logic [1:0] {
    PH_RIFF = 2'd0,
    PH_HEAD = 2'd1,
    PH_LOAD = 2'd2,
    PH_PAD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_TRUNC  = 3'd1,
    ST_RIFF   = 3'd2,
    ST_NOFMT  = 3'd3,
    ST_UNSUP  = 3'd4,
    ST_NODATA = 3'd5
  } status_t;

endpackage

// ===== rtl/core/wav_chunk_stream_parser_top.sv =====
// Top level: streaming RIFF/WAVE header parser, one byte per transaction.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | data_byte[7:0], last_byte
//  out_    | output    | out_valid/out_stall | status, channels, sample_rate,
//          |           |                     | bits_per_sample, data_offset, data_size
//
// One byte per cycle unless stalled; the result registers the cycle after the last byte.
// The next-state logic is combinational (32-bit size subtract/compare).
// rst_n is synchronous; after each result the parser returns to its reset state.
// in_stall is high only while a result sits in the output register with out_stall high.
module wav_chunk_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_bits_per_sample,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size
);

  localparam logic [wcsp_pkg::POS_BITS-1:0] POS_MAX = '1;

  logic [wcsp_pkg::POS_BITS-1:0] pos_r, pos_nxt;
  wcsp_pkg::phase_t  phase_r, phase_nxt;
  logic [63:0]       shift_r, shift_nxt;
  logic [31:0]       left_r, left_nxt;
  wcsp_pkg::kind_t   kind_r, kind_nxt;
  logic [15:0]       pfmt_r, pfmt_nxt;
  logic [15:0]       pch_r, pch_nxt;
  logic [31:0]       prate_r, prate_nxt;
  logic [15:0]       pbits_r, pbits_nxt;
  logic [31:0]       poff_r, poff_nxt;
  logic [31:0]       psize_r, psize_nxt;
  logic [15:0]       kch_r, kch_nxt;
  logic [31:0]       krate_r, krate_nxt;
  logic [15:0]       kbits_r, kbits_nxt;
  logic [31:0]       koff_r, koff_nxt;
  logic [31:0]       ksize_r, ksize_nxt;
  logic              fmt_seen_r, fmt_seen_nxt;
  logic              data_seen_r, data_seen_nxt;
  wcsp_pkg::status_t err_r, err_nxt;

  logic              out_valid_r;
  wcsp_pkg::status_t out_status_r, status_nxt;
  logic [15:0]       out_ch_r;
  logic [31:0]       out_rate_r;
  logic [15:0]       out_bits_r;
  logic [31:0]       out_off_r;
  logic [31:0]       out_size_r;

  logic        in_accept;
  logic        fin;
  logic [31:0] left_dec;
  logic [31:0] load_idx;
  logic [31:0] hdr_size;
  logic [31:0] hdr_id;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // chunk header as it stands once the incoming byte is shifted in
  assign hdr_id   = shift_r[55:24];
  assign hdr_size = {in_data_byte, shift_r[7:0], shift_r[15:8], shift_r[23:16]};
  assign left_dec = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;
  assign load_idx = psize_r - left_r;

  // Next state for one accepted byte.
  always_comb begin
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    left_nxt      = left_r;
    kind_nxt      = kind_r;
    pfmt_nxt      = pfmt_r;
    pch_nxt       = pch_r;
    prate_nxt     = prate_r;
    pbits_nxt     = pbits_r;
    poff_nxt      = poff_r;
    psize_nxt     = psize_r;
    kch_nxt       = kch_r;
    krate_nxt     = krate_r;
    kbits_nxt     = kbits_r;
    koff_nxt      = koff_r;
    ksize_nxt     = ksize_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    err_nxt       = err_r;
    fin           = 1'b0;

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end

    if (err_r == wcsp_pkg::ST_NONE) begin
      unique case (phase_r)
        wcsp_pkg::PH_RIFF: begin
          shift_nxt = {shift_r[55:0], in_data_byte};
          if (pos_r == wcsp_pkg::POS_BITS'(3) && shift_nxt[31:0] != wcsp_pkg::ID_RIFF) begin
            err_nxt = wcsp_pkg::ST_RIFF;
          end
          if (pos_r == wcsp_pkg::POS_BITS'(wcsp_pkg::RIFF_HDR_BYTES - 1)) begin
            if (shift_nxt[31:0] != wcsp_pkg::ID_WAVE) begin
              err_nxt = wcsp_pkg::ST_RIFF;
            end else begin
              phase_nxt = wcsp_pkg::PH_HEAD;
              left_nxt  = 32'(wcsp_pkg::CHUNK_HDR_BYTES);
            end
          end
        end
        wcsp_pkg::PH_HEAD: begin
          shift_nxt = {shift_r[55:0], in_data_byte};
          left_nxt  = left_dec;
          if (left_dec == 32'd0) begin
            if (hdr_id == wcsp_pkg::ID_FMT) begin
              kind_nxt = wcsp_pkg::KIND_FMT;
            end else if (hdr_id == wcsp_pkg::ID_DATA) begin
              kind_nxt = wcsp_pkg::KIND_DATA;
            end else begin
              kind_nxt = wcsp_pkg::KIND_OTHER;
            end
            psize_nxt = hdr_size;
            poff_nxt  = 32'(pos_nxt);
            pfmt_nxt  = '0;
            pch_nxt   = '0;
            prate_nxt = '0;
            pbits_nxt = '0;
            if (kind_nxt == wcsp_pkg::KIND_FMT && hdr_size < wcsp_pkg::FMT_MIN_SIZE) begin
              err_nxt = wcsp_pkg::ST_TRUNC;
            end else if (hdr_size == 32'd0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = wcsp_pkg::PH_LOAD;
              left_nxt  = hdr_size;
            end
          end
        end
        wcsp_pkg::PH_LOAD: begin
          if (kind_r == wcsp_pkg::KIND_FMT && load_idx < 32'd16) begin
            case (load_idx[3:0])
              4'd0:  pfmt_nxt[7:0]    = in_data_byte;
              4'd1:  pfmt_nxt[15:8]   = in_data_byte;
              4'd2:  pch_nxt[7:0]     = in_data_byte;
              4'd3:  pch_nxt[15:8]    = in_data_byte;
              4'd4:  prate_nxt[7:0]   = in_data_byte;
              4'd5:  prate_nxt[15:8]  = in_data_byte;
              4'd6:  prate_nxt[23:16] = in_data_byte;
              4'd7:  prate_nxt[31:24] = in_data_byte;
              4'd14: pbits_nxt[7:0]   = in_data_byte;
              4'd15: pbits_nxt[15:8]  = in_data_byte;
              default: ;
            endcase
          end
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            fin = 1'b1;
          end
        end
        wcsp_pkg::PH_PAD: begin
          phase_nxt = wcsp_pkg::PH_HEAD;
          left_nxt  = 32'(wcsp_pkg::CHUNK_HDR_BYTES);
        end
        default: ;
      endcase

      // chunk complete: commit its values
      if (fin) begin
        if (kind_nxt == wcsp_pkg::KIND_FMT) begin
          kch_nxt      = pch_nxt;
          krate_nxt    = prate_nxt;
          kbits_nxt    = pbits_nxt;
          fmt_seen_nxt = 1'b1;
          if (pfmt_nxt != wcsp_pkg::FMT_PCM || pch_nxt == 16'd0 || pch_nxt > wcsp_pkg::CH_MAX
              || (pbits_nxt != wcsp_pkg::BITS_8 && pbits_nxt != wcsp_pkg::BITS_16)) begin
            err_nxt = wcsp_pkg::ST_UNSUP;
          end
        end else if (kind_nxt == wcsp_pkg::KIND_DATA) begin
          koff_nxt      = poff_nxt;
          ksize_nxt     = psize_nxt;
          data_seen_nxt = 1'b1;
        end
        if (psize_nxt[0]) begin
          phase_nxt = wcsp_pkg::PH_PAD;
          left_nxt  = 32'd0;
        end else begin
          phase_nxt = wcsp_pkg::PH_HEAD;
          left_nxt  = 32'(wcsp_pkg::CHUNK_HDR_BYTES);
        end
      end
    end
  end

  // Result status after the byte is taken.
  always_comb begin
    if (pos_nxt < wcsp_pkg::POS_BITS'(wcsp_pkg::RIFF_HDR_BYTES)) begin
      status_nxt = wcsp_pkg::ST_TRUNC;
    end else if (err_nxt != wcsp_pkg::ST_NONE) begin
      status_nxt = err_nxt;
    end else if (phase_nxt == wcsp_pkg::PH_LOAD) begin
      status_nxt = wcsp_pkg::ST_TRUNC;
    end else if (!fmt_seen_nxt) begin
      status_nxt = wcsp_pkg::ST_NOFMT;
    end else if (!data_seen_nxt) begin
      status_nxt = wcsp_pkg::ST_NODATA;
    end else begin
      status_nxt = wcsp_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_last_byte)) begin
      pos_r       <= '0;
      phase_r     <= wcsp_pkg::PH_RIFF;
      shift_r     <= '0;
      left_r      <= '0;
      kind_r      <= wcsp_pkg::KIND_OTHER;
      pfmt_r      <= '0;
      pch_r       <= '0;
      prate_r     <= '0;
      pbits_r     <= '0;
      poff_r      <= '0;
      psize_r     <= '0;
      kch_r       <= '0;
      krate_r     <= '0;
      kbits_r     <= '0;
      koff_r      <= '0;
      ksize_r     <= '0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      err_r       <= wcsp_pkg::ST_NONE;
    end else if (in_accept) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      left_r      <= left_nxt;
      kind_r      <= kind_nxt;
      pfmt_r      <= pfmt_nxt;
      pch_r       <= pch_nxt;
      prate_r     <= prate_nxt;
      pbits_r     <= pbits_nxt;
      poff_r      <= poff_nxt;
      psize_r     <= psize_nxt;
      kch_r       <= kch_nxt;
      krate_r     <= krate_nxt;
      kbits_r     <= kbits_nxt;
      koff_r      <= koff_nxt;
      ksize_r     <= ksize_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_last_byte) begin
      out_status_r <= status_nxt;
      out_ch_r     <= kch_nxt;
      out_rate_r   <= krate_nxt;
      out_bits_r   <= kbits_nxt;
      out_off_r    <= koff_nxt;
      out_size_r   <= ksize_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_channels        = out_ch_r;
  assign out_sample_rate     = out_rate_r;
  assign out_bits_per_sample = out_bits_r;
  assign out_data_offset     = out_off_r;
  assign out_data_size       = out_size_r;

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> out_valid_r)
    else $error("no result after last byte");

  a_reset_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> pos_r == '0 && phase_r == wcsp_pkg::PH_RIFF
      && err_r == wcsp_pkg::ST_NONE)
    else $error("parser state not cleared after result");

  a_riff_phase_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wcsp_pkg::PH_RIFF && err_r == wcsp_pkg::ST_NONE
      |-> pos_r < wcsp_pkg::POS_BITS'(wcsp_pkg::RIFF_HDR_BYTES))
    else $error("RIFF header phase past byte 12");

  a_load_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wcsp_pkg::PH_LOAD && err_r == wcsp_pkg::ST_NONE |-> left_r != 32'd0
      && left_r <= psize_r)
    else $error("payload count out of range");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wcsp_pkg::PH_HEAD && err_r == wcsp_pkg::ST_NONE
      |-> left_r != 32'd0 && left_r <= 32'(wcsp_pkg::CHUNK_HDR_BYTES))
    else $error("chunk header count out of range");

endmodule
